@@ src/spq_pkg.sv @@
// Shared types and constants for the sorted max priority queue.
`default_nettype none

package spq_pkg;

	// Default number of cells in the chain
	localparam int unsigned CAPACITY_DEF = 128;

	// Width of the reported count field
	localparam int unsigned COUNT_OUT_W = 8;

	// Value returned by pop or peek on an empty queue
	localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

	// Operation codes
	typedef enum logic [1:0] {
		FUNC_PUSH = 2'd0,
		FUNC_POP  = 2'd1,
		FUNC_PEEK = 2'd2,
		FUNC_NOP  = 2'd3
	} func_t;

	// Status codes
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	// Request transaction
	typedef struct packed {
		func_t              func;
		logic signed [31:0] value;
	} req_t;

	// Result transaction
	typedef struct packed {
		logic signed [31:0]     result_value;
		status_t                status;
		logic [COUNT_OUT_W-1:0] count_after;
	} rsp_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic               push;
		logic               pop;
		logic signed [31:0] value;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ src/spq_cell.sv @@
// One compare-and-shift cell of the sorted chain.
`default_nettype none

module spq_cell (
	input  wire logic                      clk,
	input  wire spq_pkg::cell_ctl_t        ctl,
	input  wire logic                      occupied,
	input  wire logic                      left_ge,
	input  wire logic signed [31:0]        left_entry,
	input  wire logic signed [31:0]        right_entry,
	output logic                           ge,
	output logic signed [31:0]             entry
);
	import spq_pkg::*;

	logic signed [31:0] entry_q;

	// Stored entry stays ahead of the new value when greater or equal
	assign ge    = occupied && (entry_q >= ctl.value);
	assign entry = entry_q;

	// Push: keep, take the new value, or take the left neighbour; pop: take the right one
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			if (!ge) begin
				entry_q <= left_ge ? ctl.value : left_entry;
			end
		end else if (ctl.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

`default_nettype wire

@@ src/sorted_max_priority_queue.sv @@
// Top level of the sorted max priority queue: sequencer and chain of cells.
//
// Usage:
//   Drive req and raise start for one cycle per operation; the request is
//   taken at a rising edge where start is high and busy is low. busy is
//   never raised, so a new request may be issued in every cycle.
//   Operations: push inserts behind all entries that are greater or equal,
//   pop removes and returns the largest, peek returns it without removal.
//   The result appears on rsp in the cycle after the request is taken, with
//   done high for exactly that cycle. The receiver cannot stall.
//   Throughput is one operation per cycle: each cell compares its entry with the
//   new value and shifts together with its neighbours, all cells in parallel.
//   Push on a full queue drops the value and reports full; pop or peek on
//   an empty queue reports empty and returns -1. count_after carries the
//   low bits of the entry count after the operation.
//   Reset (arst_n low) empties the queue and clears done; cell contents
//   are not cleared, since only occupied cells are ever read.
`default_nettype none

module sorted_max_priority_queue #(
	parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire spq_pkg::req_t req,
	output logic               done,
	output spq_pkg::rsp_t      rsp
);
	import spq_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]           count_q;
	logic [CW-1:0]           count_nxt;
	logic                    accept;
	logic                    full;
	logic                    empty;
	cell_ctl_t               ctl;
	logic [CAPACITY-1:0]     occ;
	logic [CAPACITY-1:0]     ge;
	logic signed [31:0]      entry [CAPACITY];
	rsp_t                    rsp_nxt;
	rsp_t                    rsp_q;
	logic                    done_q;
	logic [CW+COUNT_OUT_W-1:0] count_ext;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CW'(CAPACITY));
	assign empty  = (count_q == '0);

	// Broadcast control to the chain
	assign ctl.push  = accept && (req.func == FUNC_PUSH) && !full;
	assign ctl.pop   = accept && (req.func == FUNC_POP) && !empty;
	assign ctl.value = req.value;

	// Chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic               l_ge;
		logic signed [31:0] l_entry;
		logic signed [31:0] r_entry;

		assign occ[i] = (count_q > CW'(i));

		if (i == 0) begin : g_head
			assign l_ge    = 1'b1;
			assign l_entry = ctl.value;
		end else begin : g_body
			assign l_ge    = ge[i-1];
			assign l_entry = entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign r_entry = entry[i];
		end else begin : g_inner
			assign r_entry = entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (occ[i]),
			.left_ge     (l_ge),
			.left_entry  (l_entry),
			.right_entry (r_entry),
			.ge          (ge[i]),
			.entry       (entry[i])
		);
	end

	// Next count
	always_comb begin
		count_nxt = count_q;
		if (ctl.push) begin
			count_nxt = count_q + CW'(1);
		end else if (ctl.pop) begin
			count_nxt = count_q - CW'(1);
		end
	end

	assign count_ext = {{COUNT_OUT_W{1'b0}}, count_nxt};

	// Result of the current transaction
	always_comb begin
		rsp_nxt.result_value = '0;
		rsp_nxt.status       = STATUS_OK;
		rsp_nxt.count_after  = count_ext[COUNT_OUT_W-1:0];
		unique case (req.func)
			FUNC_PUSH: begin
				if (full) begin
					rsp_nxt.status = STATUS_FULL;
				end
			end
			FUNC_POP, FUNC_PEEK: begin
				if (empty) begin
					rsp_nxt.result_value = EMPTY_VALUE;
					rsp_nxt.status       = STATUS_EMPTY;
				end else begin
					rsp_nxt.result_value = entry[0];
				end
			end
			FUNC_NOP: begin
			end
			default: begin
			end
		endcase
	end

	// Count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= accept;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("no result after accepted transaction");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not grow the count");

	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == STATUS_EMPTY |-> rsp.result_value == EMPTY_VALUE)
		else $error("empty status without -1");

	a_head_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		occ[1] |-> entry[0] >= entry[1])
		else $error("chain head out of order");
`endif

endmodule

`default_nettype wire

@@ dv/sorted_max_priority_queue_tb.sv @@
// Self-checking testbench for the sorted max priority queue: directed and random operations.
`default_nettype none

module sorted_max_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int QUEUE_DEPTH  = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 1830;
	localparam int STALL_LIMIT  = 1000;
	localparam int MAX_REPORTS  = 10;
	localparam int DRAIN_CYCLES = 4;

	// Random segments lean towards filling, draining or a mixture
	typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	req_t req = '0;
	rsp_t rsp;

	req_t               pending_reqs[$];
	rsp_t               expected_rsps[$];
	logic signed [31:0] held_values[$];   // shadow of the chain, largest first
	int                 mismatch_count = 0;
	int                 issued_count = 0;
	int                 stall_cycles = 0;
	int                 total_items = 0;

	sorted_max_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic signed [31:0] pick_value();
		logic signed [31:0] corners [5] = '{32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sd0,
			32'sd1};
		int roll;
		roll = $urandom_range(99);
		if (roll < 15)
			return corners[$urandom_range(4)];
		else if (roll < 50)
			return $urandom_range(16) - 8;   // narrow band, plenty of ties
		else
			return $urandom();
	endfunction

	task automatic add_item(func_t f, logic signed [31:0] v);
		req_t r;
		r.func = f;
		r.value = v;
		pending_reqs.push_back(r);
	endtask

	// Apply one transaction to the shadow queue and return what the block should answer
	function automatic rsp_t queue_apply(req_t r);
		rsp_t o;
		int pos;
		o.result_value = '0;
		o.status = STATUS_OK;
		case (r.func)
			FUNC_PUSH: begin
				if (held_values.size() >= QUEUE_DEPTH) begin
					o.status = STATUS_FULL;
				end else begin
					// behind every entry that is greater or equal
					pos = 0;
					while (pos < held_values.size() && held_values[pos] >= r.value)
						pos++;
					held_values.insert(pos, r.value);
				end
			end
			FUNC_POP, FUNC_PEEK: begin
				if (held_values.size() == 0) begin
					o.result_value = EMPTY_VALUE;
					o.status = STATUS_EMPTY;
				end else if (r.func == FUNC_POP) begin
					o.result_value = held_values.pop_front();
				end else begin
					o.result_value = held_values[0];
				end
			end
			default: begin
			end
		endcase
		o.count_after = COUNT_OUT_W'(held_values.size());
		return o;
	endfunction

	task automatic flag_error(string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Driver: present the next pending request once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		int idle_pct;
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else if (!start || !busy) begin
			if (issued_count < total_items / 3)
				idle_pct = 30;
			else if (issued_count < 2 * total_items / 3)
				idle_pct = 78;
			else
				idle_pct = 0;
			if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				req <= pending_reqs.pop_front();
				issued_count <= issued_count + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: check results against the oldest expectation, then predict new transactions
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_rsps.size() == 0) begin
					flag_error($sformatf("unexpected result value=%0d status=%0d count=%0d",
						rsp.result_value, rsp.status, rsp.count_after));
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.result_value !== want.result_value || rsp.status !== want.status
							|| rsp.count_after !== want.count_after)
						flag_error($sformatf({"mismatch: value exp %0d got %0d, ",
							"status exp %0d got %0d, count exp %0d got %0d"},
							want.result_value, rsp.result_value, want.status, rsp.status,
							want.count_after, rsp.count_after));
				end
			end
			if (start && !busy)
				expected_rsps.push_back(queue_apply(req));
		end
	end

	// Watchdog: cycles with neither a request nor a result taken
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		seg_kind_t kind;
		int seg_len;
		int roll;
		int push_lim;
		int pop_lim;
		int peek_lim;
		int n;
		func_t f;

		// Empty queue corners
		add_item(FUNC_PEEK, 32'sd7);
		add_item(FUNC_POP, -32'sd7);
		add_item(FUNC_NOP, 32'sh12345678);
		// Extremes and ties, then drain past empty
		add_item(FUNC_PUSH, 32'sd5);
		add_item(FUNC_PUSH, 32'sd5);
		add_item(FUNC_PUSH, 32'sh7fffffff);
		add_item(FUNC_PUSH, 32'sh80000000);
		add_item(FUNC_PUSH, -32'sd1);
		add_item(FUNC_PUSH, 32'sd0);
		add_item(FUNC_PUSH, 32'sd5);
		add_item(FUNC_PEEK, 32'shffffffff);
		add_item(FUNC_NOP, 32'sh80000000);
		repeat (7) add_item(FUNC_POP, $urandom());
		add_item(FUNC_POP, 32'sd0);
		add_item(FUNC_PEEK, 32'sd0);

		// Random segments; long fill runs reach the full case
		n = 0;
		while (n < RANDOM_ITEMS) begin
			kind = seg_kind_t'($urandom_range(2));
			seg_len = $urandom_range(20, 200);
			if (seg_len > RANDOM_ITEMS - n)
				seg_len = RANDOM_ITEMS - n;
			case (kind)
				SEG_FILL: begin
					push_lim = 88; pop_lim = 94; peek_lim = 98;
				end
				SEG_DRAIN: begin
					push_lim = 8; pop_lim = 86; peek_lim = 96;
				end
				default: begin
					push_lim = 45; pop_lim = 80; peek_lim = 95;
				end
			endcase
			repeat (seg_len) begin
				roll = $urandom_range(99);
				if (roll < push_lim)
					f = FUNC_PUSH;
				else if (roll < pop_lim)
					f = FUNC_POP;
				else if (roll < peek_lim)
					f = FUNC_PEEK;
				else
					f = FUNC_NOP;
				add_item(f, pick_value());
				n++;
			end
		end
		total_items = pending_reqs.size();

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || start)
			@(negedge clk);
		while (expected_rsps.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && expected_rsps.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
